@@ src/ktl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktl_pkg: shared constants for the keyframe track interpolator
// Table depth, field widths and command codes.
// ----------------------------------------------------------------------------
package ktl_pkg;
  localparam int KeyDepth = 64;
  localparam int IdxW     = $clog2(KeyDepth);
  localparam int CntW     = 7;
  localparam int TimeW    = 24;
  localparam int ValW     = 32;
  localparam int FracW    = 16;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;
endpackage

@@ src/keyframe_track_lerp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_track_lerp: keyframe track store with linear interpolation
// Binary search over the key table, serial factor division, shared mixer.
// ----------------------------------------------------------------------------
// A load word gives no result. A query word runs a binary search that
// reads the table once per step, up to seven steps; two more reads then
// fetch the bracketing keys, the serial divider forms the blend factor, and
// one shared multiplier blends the three components in turn. Busy stays
// high for the whole query. The result is shown for one cycle on out_valid
// and cannot be held off by the receiver; out_of_range marks a frame
// outside the track.
module keyframe_track_lerp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_command,
  input  logic [ktl_pkg::IdxW-1:0]           in_key_index,
  input  logic [ktl_pkg::TimeW-1:0]          in_key_time,
  input  logic signed [ktl_pkg::ValW-1:0]    in_value_x,
  input  logic signed [ktl_pkg::ValW-1:0]    in_value_y,
  input  logic signed [ktl_pkg::ValW-1:0]    in_value_z,
  input  logic [ktl_pkg::TimeW-1:0]          in_query_frame,
  input  logic                               cfg_we,
  input  logic [ktl_pkg::CntW-1:0]           cfg_key_count,
  output logic                               out_valid,
  output logic signed [ktl_pkg::ValW-1:0]    out_x,
  output logic signed [ktl_pkg::ValW-1:0]    out_y,
  output logic signed [ktl_pkg::ValW-1:0]    out_z,
  output logic                               out_of_range
);
  localparam int EntW = ktl_pkg::TimeW + 3 * ktl_pkg::ValW;
  localparam int LenW = ktl_pkg::IdxW + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_RD_PREV, S_RD_NEXT, S_GOT_NEXT,
    S_DIV, S_MIX, S_MIX_ACC, S_DONE
  } state_t;

  state_t                        state_r;
  logic [EntW-1:0]               mem [ktl_pkg::KeyDepth];
  logic [EntW-1:0]               rd_data_r;
  logic [ktl_pkg::IdxW-1:0]      rd_addr;
  logic [ktl_pkg::CntW-1:0]      key_count_r;
  logic [LenW-1:0]               n_r, lo_r, len_r, half;
  logic [ktl_pkg::TimeW-1:0]     frame_r, t_prev_r;
  logic signed [ktl_pkg::ValW-1:0] v_prev_r [3];
  logic signed [ktl_pkg::ValW-1:0] res_r [3];
  logic [1:0]                    comp_r;
  logic signed [ktl_pkg::ValW:0] diff_r;
  logic signed [ktl_pkg::ValW+ktl_pkg::FracW+1:0] prod_r;
  logic                          oor_r, valid_r, div_start_r, div_done;
  logic [ktl_pkg::TimeW-1:0]     div_num_r, div_den_r;
  logic [ktl_pkg::FracW-1:0]     factor;
  logic [ktl_pkg::TimeW-1:0]     rd_time;
  logic signed [ktl_pkg::ValW-1:0] rd_val [3];
  logic                          accept;

  assign accept  = start && (state_r == S_IDLE);
  assign half    = len_r >> 1;
  assign rd_time = rd_data_r[EntW-1 -: ktl_pkg::TimeW];
  assign rd_val[0] = rd_data_r[3*ktl_pkg::ValW-1 -: ktl_pkg::ValW];
  assign rd_val[1] = rd_data_r[2*ktl_pkg::ValW-1 -: ktl_pkg::ValW];
  assign rd_val[2] = rd_data_r[ktl_pkg::ValW-1:0];

  always_comb begin
    case (state_r)
      S_RD_PREV: rd_addr = ktl_pkg::IdxW'(lo_r - LenW'(1));
      S_RD_NEXT: rd_addr = lo_r[ktl_pkg::IdxW-1:0];
      default:   rd_addr = ktl_pkg::IdxW'(lo_r + half);
    endcase
  end

  // Table: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (accept && in_command == ktl_pkg::CMD_LOAD)
      mem[in_key_index] <= {in_key_time, in_value_x, in_value_y, in_value_z};
    rd_data_r <= mem[rd_addr];
  end

  ktl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (div_num_r),
    .den   (div_den_r),
    .done  (div_done),
    .quot  (factor)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      key_count_r <= ktl_pkg::CntW'(2);
      valid_r     <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      valid_r     <= 1'b0;
      div_start_r <= 1'b0;
      if (cfg_we)
        key_count_r <= cfg_key_count;
      case (state_r)
        S_IDLE: begin
          if (accept && in_command == ktl_pkg::CMD_QUERY) begin
            frame_r <= in_query_frame;
            n_r     <= (key_count_r > ktl_pkg::CntW'(ktl_pkg::KeyDepth))
                       ? LenW'(ktl_pkg::KeyDepth) : LenW'(key_count_r);
            len_r   <= (key_count_r > ktl_pkg::CntW'(ktl_pkg::KeyDepth))
                       ? LenW'(ktl_pkg::KeyDepth) : LenW'(key_count_r);
            lo_r    <= '0;
            state_r <= S_SRCH_RD;
          end
        end
        S_SRCH_RD: begin
          if (len_r == '0) begin
            if (lo_r == '0 || lo_r >= n_r) begin
              oor_r   <= 1'b1;
              state_r <= S_DONE;
            end else begin
              oor_r   <= 1'b0;
              state_r <= S_RD_PREV;
            end
          end else begin
            state_r <= S_SRCH_CMP;
          end
        end
        S_SRCH_CMP: begin
          if (rd_time <= frame_r) begin
            lo_r  <= lo_r + half + LenW'(1);
            len_r <= len_r - half - LenW'(1);
          end else begin
            len_r <= half;
          end
          state_r <= S_SRCH_RD;
        end
        S_RD_PREV: state_r <= S_RD_NEXT;
        S_RD_NEXT: begin
          t_prev_r    <= rd_time;
          v_prev_r[0] <= rd_val[0];
          v_prev_r[1] <= rd_val[1];
          v_prev_r[2] <= rd_val[2];
          state_r     <= S_GOT_NEXT;
        end
        S_GOT_NEXT: begin
          // Next key stays in the read register while the divider runs.
          div_num_r   <= frame_r - t_prev_r;
          div_den_r   <= rd_time - t_prev_r;
          div_start_r <= 1'b1;
          state_r     <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            comp_r  <= 2'd0;
            diff_r  <= (ktl_pkg::ValW+1)'(rd_val[0]) - (ktl_pkg::ValW+1)'(v_prev_r[0]);
            state_r <= S_MIX;
          end
        end
        S_MIX: begin
          prod_r  <= diff_r * $signed({2'b00, factor});
          state_r <= S_MIX_ACC;
        end
        S_MIX_ACC: begin
          res_r[comp_r] <= v_prev_r[comp_r]
                           + ktl_pkg::ValW'(prod_r >>> ktl_pkg::FracW);
          if (comp_r == 2'd2) begin
            state_r <= S_DONE;
          end else begin
            comp_r  <= comp_r + 2'd1;
            diff_r  <= (ktl_pkg::ValW+1)'(rd_val[comp_r + 2'd1])
                       - (ktl_pkg::ValW+1)'(v_prev_r[comp_r + 2'd1]);
            state_r <= S_MIX;
          end
        end
        S_DONE: begin
          valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = valid_r;
  assign out_of_range = oor_r;
  assign out_x        = oor_r ? '0 : res_r[0];
  assign out_y        = oor_r ? '0 : res_r[1];
  assign out_z        = oor_r ? '0 : res_r[2];

  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside the divide state");
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SRCH_RD |-> (lo_r + len_r) <= n_r)
    else $error("search window beyond key count");
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
  a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy while result shown");
endmodule

@@ src/ktl_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ktl_div: serial restoring divider for the blend factor
// Computes floor((num << 16) / den), one quotient bit per cycle, num < den.
// ----------------------------------------------------------------------------
module ktl_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ktl_pkg::TimeW-1:0]   num,
  input  logic [ktl_pkg::TimeW-1:0]   den,
  output logic                        done,
  output logic [ktl_pkg::FracW-1:0]   quot
);
  logic [ktl_pkg::TimeW:0]     rem_r, rem_nxt;
  logic [ktl_pkg::TimeW-1:0]   den_r;
  logic [ktl_pkg::FracW-1:0]   q_r, q_nxt;
  logic [4:0]                  cnt_r;
  logic                        busy_r, done_r;
  logic [ktl_pkg::TimeW+1:0]   trial;

  always_comb begin
    trial   = {rem_r, 1'b0} - {2'b00, den_r};
    rem_nxt = {rem_r[ktl_pkg::TimeW-1:0], 1'b0};
    q_nxt   = {q_r[ktl_pkg::FracW-2:0], 1'b0};
    if (!trial[ktl_pkg::TimeW+1]) begin
      rem_nxt = trial[ktl_pkg::TimeW:0];
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd0;
        rem_r  <= {1'b0, num};
        den_r  <= den;
        q_r    <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        q_r   <= q_nxt;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(ktl_pkg::FracW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

@@ tb/tb_keyframe_track_lerp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyframe_track_lerp: regression for the keyframe track interpolator
// Loads sorted and scrambled key tracks, queries frames across and outside
// them under several key counts and idling patterns, and checks every
// interpolated word against a cycle-free predictor held in a scoreboard.
// ----------------------------------------------------------------------------
module tb_keyframe_track_lerp;

  localparam int  Limit = 1500000;
  localparam int  Drain = 60;
  localparam logic [ktl_pkg::TimeW-1:0] TMax = {ktl_pkg::TimeW{1'b1}};

  typedef struct {
    logic [ktl_pkg::ValW-1:0] x, y, z;
    logic                     oor;
  } lerp_t;

  class lerp_board;
    logic [ktl_pkg::TimeW-1:0] times[ktl_pkg::KeyDepth];
    logic [ktl_pkg::ValW-1:0]  kx[ktl_pkg::KeyDepth], ky[ktl_pkg::KeyDepth];
    logic [ktl_pkg::ValW-1:0]  kz[ktl_pkg::KeyDepth];
    int unsigned      count = 2;
    lerp_t            waiting[$];
    int               errors = 0;

    function automatic logic [ktl_pkg::ValW-1:0] blend(logic [ktl_pkg::ValW-1:0] a,
                                                       logic [ktl_pkg::ValW-1:0] b,
                                                       logic [ktl_pkg::FracW-1:0] f);
      longint d, p;
      d = longint'($signed(b)) - longint'($signed(a));
      p = d * longint'(f);
      return ktl_pkg::ValW'(longint'($signed(a)) + (p >>> 16));
    endfunction

    function void note_word(logic cmd, logic [ktl_pkg::IdxW-1:0] idx,
                            logic [ktl_pkg::TimeW-1:0] t,
                            logic [ktl_pkg::ValW-1:0] vx, logic [ktl_pkg::ValW-1:0] vy,
                            logic [ktl_pkg::ValW-1:0] vz, logic [ktl_pkg::TimeW-1:0] frame);
      int unsigned n, lo, len, half, mid;
      logic [63:0] num, span, f;
      lerp_t r;
      if (cmd == ktl_pkg::CMD_LOAD) begin
        times[idx] = t; kx[idx] = vx; ky[idx] = vy; kz[idx] = vz;
        return;
      end
      n = (count < ktl_pkg::KeyDepth) ? count : ktl_pkg::KeyDepth;
      lo = 0; len = n;
      while (len > 0) begin
        half = len / 2;
        mid = lo + half;
        if (times[mid] <= frame) begin
          lo = mid + 1; len = len - half - 1;
        end else begin
          len = half;
        end
      end
      if (lo == 0 || lo >= n) begin
        r = '{x: '0, y: '0, z: '0, oor: 1'b1};
      end else begin
        span = 64'(times[lo]) - 64'(times[lo-1]);
        num = 64'(frame) - 64'(times[lo-1]);
        f = (num << 16) / span;
        if (f > 64'hFFFF) f = 64'hFFFF;
        r.x = blend(kx[lo-1], kx[lo], f[ktl_pkg::FracW-1:0]);
        r.y = blend(ky[lo-1], ky[lo], f[ktl_pkg::FracW-1:0]);
        r.z = blend(kz[lo-1], kz[lo], f[ktl_pkg::FracW-1:0]);
        r.oor = 1'b0;
      end
      waiting.push_back(r);
    endfunction

    function void check_word(logic [ktl_pkg::ValW-1:0] x, logic [ktl_pkg::ValW-1:0] y,
                             logic [ktl_pkg::ValW-1:0] z, logic oor);
      lerp_t e;
      if (waiting.size() == 0) begin
        $error("unexpected result word: x=%h y=%h z=%h out_of_range=%b", x, y, z, oor);
        errors++;
        return;
      end
      e = waiting.pop_front();
      if (x !== e.x) begin $error("out_x: expected %h, got %h", e.x, x); errors++; end
      if (y !== e.y) begin $error("out_y: expected %h, got %h", e.y, y); errors++; end
      if (z !== e.z) begin $error("out_z: expected %h, got %h", e.z, z); errors++; end
      if (oor !== e.oor) begin
        $error("out_of_range: expected %b, got %b", e.oor, oor); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_command = ktl_pkg::CMD_LOAD;
  logic [ktl_pkg::IdxW-1:0] in_key_index = '0;
  logic [ktl_pkg::TimeW-1:0] in_key_time = '0;
  logic signed [ktl_pkg::ValW-1:0] in_value_x = '0, in_value_y = '0, in_value_z = '0;
  logic [ktl_pkg::TimeW-1:0] in_query_frame = '0;
  logic cfg_we = 1'b0;
  logic [ktl_pkg::CntW-1:0] cfg_key_count = '0;
  logic out_valid;
  logic signed [ktl_pkg::ValW-1:0] out_x, out_y, out_z;
  logic out_of_range;

  lerp_board board = new();
  int unsigned cycles = 0;
  int unsigned idle_pct = 0;
  logic [ktl_pkg::TimeW-1:0] track_lo, track_hi;

  always #2 clk = ~clk;

  keyframe_track_lerp u_dut (
    .clk, .rst_n, .start, .busy, .in_command, .in_key_index, .in_key_time,
    .in_value_x, .in_value_y, .in_value_z, .in_query_frame, .cfg_we, .cfg_key_count,
    .out_valid, .out_x, .out_y, .out_z, .out_of_range
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > Limit) begin
      $display("keyframe_track_lerp regression: fail");
      $finish;
    end
    if (rst_n && out_valid) board.check_word(out_x, out_y, out_z, out_of_range);
  end

  task automatic send_word(logic cmd, logic [ktl_pkg::IdxW-1:0] idx,
                           logic [ktl_pkg::TimeW-1:0] t,
                           logic [ktl_pkg::ValW-1:0] vx, logic [ktl_pkg::ValW-1:0] vy,
                           logic [ktl_pkg::ValW-1:0] vz, logic [ktl_pkg::TimeW-1:0] frame);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 8) : 0;
    repeat (gap) begin
      @(negedge clk) start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    in_command = cmd; in_key_index = idx; in_key_time = t;
    in_value_x = vx; in_value_y = vy; in_value_z = vz; in_query_frame = frame;
    do @(posedge clk); while (busy);
    board.note_word(cmd, idx, t, vx, vy, vz, frame);
  endtask

  task automatic load_key(int idx, logic [ktl_pkg::TimeW-1:0] t);
    send_word(ktl_pkg::CMD_LOAD, ktl_pkg::IdxW'(idx), t, $urandom, $urandom, $urandom,
              ktl_pkg::TimeW'($urandom));
  endtask

  task automatic query(logic [ktl_pkg::TimeW-1:0] frame);
    send_word(ktl_pkg::CMD_QUERY, ktl_pkg::IdxW'($urandom), ktl_pkg::TimeW'($urandom),
              $urandom, $urandom, $urandom, frame);
  endtask

  // Lower start and wait until every expected word has come back.
  task automatic drain_results();
    @(negedge clk) start = 1'b0;
    while (board.waiting.size() != 0) @(posedge clk);
  endtask

  // A load gives no result, so the block may still be busy after the last
  // expected word; lower start and wait out a full query time as well.
  task automatic settle();
    drain_results();
    repeat (Drain) @(posedge clk);
  endtask

  task automatic set_count(int unsigned cnt);
    settle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_key_count = ktl_pkg::CntW'(cnt);
    @(negedge clk) cfg_we = 1'b0;
    board.count = cnt;
  endtask

  // Sorted track over slots 0..n-1, small steps mostly, with repeated times
  // now and then.
  task automatic load_track(int n);
    logic [ktl_pkg::TimeW-1:0] t;
    int unsigned step;
    t = ($urandom_range(3) == 0) ? '0 : ktl_pkg::TimeW'($urandom_range(0, 4000));
    track_lo = t;
    for (int i = 0; i < n; i++) begin
      load_key(i, t);
      track_hi = t;
      case ($urandom_range(9))
        0: step = 0;
        1: step = $urandom_range(1, 250000);
        default: step = $urandom_range(1, 3000);
      endcase
      t = ktl_pkg::TimeW'(t + step);
      if (t < track_hi) t = track_hi;
    end
  endtask

  function automatic logic [ktl_pkg::TimeW-1:0] pick_frame();
    logic [31:0] w;
    case ($urandom_range(9))
      0: return ktl_pkg::TimeW'($urandom);
      1: return (track_lo > 0) ? ktl_pkg::TimeW'(track_lo - 1) : track_lo;
      2: return track_hi;
      default: begin
        w = $urandom_range(track_lo, track_hi + 2);
        return (w > TMax) ? TMax : ktl_pkg::TimeW'(w);
      end
    endcase
  endfunction

  initial begin
    int unsigned counts[8];
    int nk;
    counts = '{64, 0, 1, 127, 65, 2, 17, 64};
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Every slot is written before the first query, so no search can touch
    // an unwritten entry.
    load_track(ktl_pkg::KeyDepth);
    set_count(2);
    query(track_lo); query(track_hi); query('0); query(TMax);

    // Extreme values across the whole time range.
    send_word(ktl_pkg::CMD_LOAD, ktl_pkg::IdxW'(0), '0, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h0, '0);
    send_word(ktl_pkg::CMD_LOAD, ktl_pkg::IdxW'(1), TMax, 32'h7FFF_FFFF, 32'h8000_0000,
              32'hFFFF_FFFF, TMax);
    query('0); query(ktl_pkg::TimeW'(1)); query(ktl_pkg::TimeW'(TMax - 1)); query(TMax);
    query(24'h800000);
    set_count(64);
    query(ktl_pkg::TimeW'(TMax - 1)); query(TMax);
    send_word(ktl_pkg::CMD_LOAD, ktl_pkg::IdxW'(63), TMax, 32'h1, 32'h2, 32'h3, '0);
    query(ktl_pkg::TimeW'(TMax - 1));

    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = (ph % 4 == 1) ? 56 : (ph % 4 == 2) ? 10 : 0;
      if (ph == 6) counts[ph] = $urandom_range(3, 63);
      set_count(counts[ph]);
      nk = (counts[ph] < ktl_pkg::KeyDepth) ? counts[ph] : ktl_pkg::KeyDepth;
      load_track(nk);
      for (int q = 0; q < 50; q++) begin
        if (ph == 1 && q == 25) drain_results();
        if ($urandom_range(99) < 8)
          send_word(ktl_pkg::CMD_LOAD, ktl_pkg::IdxW'($urandom), ktl_pkg::TimeW'($urandom),
                    $urandom, $urandom, $urandom, ktl_pkg::TimeW'($urandom));
        else if ($urandom_range(99) < 2)
          load_track(nk);
        else
          query(pick_frame());
      end
    end

    settle();
    if (board.errors == 0 && board.waiting.size() == 0) begin
      $display("keyframe_track_lerp regression: pass");
    end else begin
      if (board.waiting.size() != 0)
        $error("%0d expected result words never arrived", board.waiting.size());
      $display("keyframe_track_lerp regression: fail");
    end
    $finish;
  end
endmodule

@@ keyframe_track_lerp.f @@
src/ktl_pkg.sv
src/ktl_div.sv
src/keyframe_track_lerp.sv
tb/tb_keyframe_track_lerp.sv
